// ----- design/lsc_pkg.sv -----
package lsc_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int U_FRAC_BITS = 16;
  localparam int NUM_EDGES   = 4;
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_X_MAX = 2'd1,
    REG_Y_MIN = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic pzero;
    logic pneg;
    logic rneg;
  } edge_flags_t;

  typedef edge_flags_t [NUM_EDGES-1:0] edge_set_t;

endpackage

// ----- design/lsc_front.sv -----
module lsc_front #(
  parameter int W = lsc_pkg::COORD_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic signed [W-1:0]        x1,
  input  logic signed [W-1:0]        y1,
  input  logic signed [W-1:0]        x2,
  input  logic signed [W-1:0]        y2,
  input  logic signed [W-1:0]        x_min,
  input  logic signed [W-1:0]        x_max,
  input  logic signed [W-1:0]        y_min,
  input  logic signed [W-1:0]        y_max,
  output logic                       out_valid,
  output logic signed [W-1:0]        out_x1,
  output logic signed [W-1:0]        out_y1,
  output logic signed [W:0]          out_dx,
  output logic signed [W:0]          out_dy,
  output logic [W-1:0]               aq [lsc_pkg::NUM_EDGES],
  output logic [W-1:0]               ap [lsc_pkg::NUM_EDGES],
  output lsc_pkg::edge_set_t         flags,
  output logic                       pre_reject
);

  logic              a_valid;
  logic signed [W-1:0] a_x1, a_y1;
  logic signed [W:0] a_dx, a_dy;
  logic signed [W:0] a_q [lsc_pkg::NUM_EDGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    a_x1   <= x1;
    a_y1   <= y1;
    a_dx   <= (W+1)'(x2) - (W+1)'(x1);
    a_dy   <= (W+1)'(y2) - (W+1)'(y1);
    a_q[0] <= (W+1)'(x1) - (W+1)'(x_min);
    a_q[1] <= (W+1)'(x_max) - (W+1)'(x1);
    a_q[2] <= (W+1)'(y1) - (W+1)'(y_min);
    a_q[3] <= (W+1)'(y_max) - (W+1)'(y1);
  end

  logic [W-1:0]       b_aq [lsc_pkg::NUM_EDGES];
  logic [W-1:0]       b_ap [lsc_pkg::NUM_EDGES];
  lsc_pkg::edge_set_t b_flags;
  logic               b_reject;

  always_comb begin
    logic signed [W:0] d;
    logic signed [W:0] nq;
    logic signed [W:0] nd;
    logic dneg;
    logic dzero;
    logic qneg;
    logic pneg;
    b_reject = 1'b0;
    for (int e = 0; e < lsc_pkg::NUM_EDGES; e++) begin
      d     = (e < 2) ? a_dx : a_dy;
      dneg  = d[W];
      dzero = (d == '0);
      qneg  = a_q[e][W];
      pneg  = ((e % 2) == 0) ? (!dneg && !dzero) : dneg;
      nq    = -a_q[e];
      nd    = -d;
      b_aq[e] = qneg ? nq[W-1:0] : a_q[e][W-1:0];
      b_ap[e] = dneg ? nd[W-1:0] : d[W-1:0];
      b_flags[e].pzero = dzero;
      b_flags[e].pneg  = pneg;
      b_flags[e].rneg  = qneg != pneg;
      if (dzero && qneg) begin
        b_reject = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
    out_x1     <= a_x1;
    out_y1     <= a_y1;
    out_dx     <= a_dx;
    out_dy     <= a_dy;
    aq         <= b_aq;
    ap         <= b_ap;
    flags      <= b_flags;
    pre_reject <= b_reject;
  end

endmodule

// ----- design/lsc_div.sv -----
module lsc_div #(
  parameter int AW = lsc_pkg::COORD_WIDTH,
  parameter int UF = lsc_pkg::U_FRAC_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [AW-1:0] aq,
  input  logic [AW-1:0] ap,
  output logic          out_valid,
  output logic [UF:0]   ratio
);

  localparam int NB = UF + 2;
  localparam logic [NB-1:0] CAP = NB'((1 << UF) + 1);

  logic [AW-1:0] rem [NB];
  logic [AW-1:0] den [NB];
  logic [NB-1:0] quo [NB];
  logic [NB-1:0] sat;
  logic [NB-1:0] vld;

  logic ge0;
  logic sat0;
  assign ge0  = aq >= ap;
  assign sat0 = {1'b0, aq} >= {ap, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0] <= ge0 ? aq - ap : aq;
    den[0] <= ap;
    quo[0] <= NB'(ge0);
    sat[0] <= sat0;
  end

  for (genvar k = 1; k < NB; k++) begin : g_step
    logic [AW:0] t;
    logic [AW:0] diff;
    logic        ge;
    assign t    = {rem[k-1], 1'b0};
    assign diff = t - {1'b0, den[k-1]};
    assign ge   = t >= {1'b0, den[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k] <= ge ? diff[AW-1:0] : t[AW-1:0];
      den[k] <= den[k-1];
      quo[k] <= {quo[k-1][NB-2:0], ge};
      sat[k] <= sat[k-1];
    end
  end

  logic [NB:0]   qp1;
  logic [NB-1:0] half;
  logic [UF:0]   ratio_next;
  assign qp1        = {1'b0, quo[NB-1]} + (NB+1)'(1);
  assign half       = qp1[NB:1];
  assign ratio_next = (sat[NB-1] || half > CAP) ? CAP[UF:0] : half[UF:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[NB-1];
    end
    ratio <= ratio_next;
  end

`ifndef NO_ASSERTIONS
  a_ratio_capped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, ratio} <= CAP))
    else $error("ratio above saturation cap");

  a_first_rem: assert property (@(posedge clk) disable iff (rst)
    vld[0] && !sat[0] |-> rem[0] < den[0])
    else $error("first partial remainder not reduced");
`endif

endmodule

// ----- design/lsc_interp.sv -----
module lsc_interp #(
  parameter int W  = lsc_pkg::COORD_WIDTH,
  parameter int UF = lsc_pkg::U_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [UF:0]         ratio [lsc_pkg::NUM_EDGES],
  input  lsc_pkg::edge_set_t  flags,
  input  logic                pre_reject,
  input  logic signed [W-1:0] x1,
  input  logic signed [W-1:0] y1,
  input  logic signed [W:0]   dx,
  input  logic signed [W:0]   dy,
  output logic                out_valid,
  output logic                visible,
  output logic signed [W-1:0] out_x1,
  output logic signed [W-1:0] out_y1,
  output logic signed [W-1:0] out_x2,
  output logic signed [W-1:0] out_y2
);

  localparam int MW = W + UF + 1;
  localparam logic signed [UF+1:0] ONE = (UF+2)'(1 << UF);

  logic signed [UF+1:0] u1, u2;
  logic                 ok;

  always_comb begin
    logic signed [UF+1:0] rs;
    u1 = '0;
    u2 = ONE;
    for (int e = 0; e < lsc_pkg::NUM_EDGES; e++) begin
      rs = flags[e].rneg ? -$signed({1'b0, ratio[e]}) : $signed({1'b0, ratio[e]});
      if (!flags[e].pzero) begin
        if (flags[e].pneg) begin
          if (rs > u1) begin
            u1 = rs;
          end
        end else if (rs < u2) begin
          u2 = rs;
        end
      end
    end
    ok = !pre_reject && !(u1 > u2);
  end

  logic                c_valid, c_ok;
  logic [UF:0]         c_u1, c_u2;
  logic signed [W-1:0] c_x1, c_y1;
  logic signed [W:0]   c_dx, c_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= in_valid;
    end
    c_ok <= ok;
    c_u1 <= u1[UF:0];
    c_u2 <= u2[UF:0];
    c_x1 <= x1;
    c_y1 <= y1;
    c_dx <= dx;
    c_dy <= dy;
  end

  logic signed [W:0] ndx, ndy;
  logic [W-1:0]      adx, ady;
  assign ndx = -c_dx;
  assign ndy = -c_dy;
  assign adx = c_dx[W] ? ndx[W-1:0] : c_dx[W-1:0];
  assign ady = c_dy[W] ? ndy[W-1:0] : c_dy[W-1:0];

  logic                d_valid, d_ok;
  logic [MW-1:0]       d_mx1, d_my1, d_mx2, d_my2;
  logic signed [W-1:0] d_x1, d_y1;
  logic signed [W:0]   d_dx, d_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= c_valid;
    end
    d_ok  <= c_ok;
    d_mx1 <= MW'(adx) * MW'(c_u1);
    d_my1 <= MW'(ady) * MW'(c_u1);
    d_mx2 <= MW'(adx) * MW'(c_u2);
    d_my2 <= MW'(ady) * MW'(c_u2);
    d_x1  <= c_x1;
    d_y1  <= c_y1;
    d_dx  <= c_dx;
    d_dy  <= c_dy;
  end

  function automatic logic [W-1:0] lerp_fn(logic signed [W-1:0] a, logic neg,
                                           logic [MW-1:0] m);
    logic [MW:0]         s;
    logic [W+1:0]        r;
    logic signed [W+1:0] ae;
    logic signed [W+1:0] res;
    s   = {1'b0, m} + ((MW+1)'(1) << (UF - 1));
    r   = s[MW:UF];
    ae  = (W+2)'(a);
    res = neg ? ae - $signed(r) : ae + $signed(r);
    return res[W-1:0];
  endfunction

  logic [W:0] x2_full, y2_full;
  assign x2_full = (W+1)'(d_x1) + d_dx;
  assign y2_full = (W+1)'(d_y1) + d_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid;
    end
    visible <= d_ok;
    if (d_ok) begin
      out_x1 <= lerp_fn(d_x1, d_dx[W], d_mx1);
      out_y1 <= lerp_fn(d_y1, d_dy[W], d_my1);
      out_x2 <= lerp_fn(d_x1, d_dx[W], d_mx2);
      out_y2 <= lerp_fn(d_y1, d_dy[W], d_my2);
    end else begin
      out_x1 <= d_x1;
      out_y1 <= d_y1;
      out_x2 <= x2_full[W-1:0];
      out_y2 <= y2_full[W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  a_u_order: assert property (@(posedge clk) disable iff (rst)
    c_valid && c_ok |-> c_u1 <= c_u2)
    else $error("entry parameter beyond exit parameter on accepted segment");

  a_u_range: assert property (@(posedge clk) disable iff (rst)
    c_valid && c_ok |-> c_u2 <= ONE[UF:0])
    else $error("exit parameter above one");
`endif

endmodule

// ----- design/line_segment_clip_unit.sv -----
// Line segment clipper against an axis-aligned window.
// Input: drive start high with start_x/start_y/end_x/end_y; busy stays low, so
// a segment word is taken at every clock edge where start is high.
// Output: done pulses for one cycle with visible and the four clip_* ports.
// A rejected segment returns visible low and its original endpoints.
// The clipper takes one segment per cycle. The ratio dividers resolve one
// quotient bit per stage over U_FRAC_BITS + 2 stages, four lanes in parallel.
// Window registers sit on the APB port at 0x0 x_min, 0x4 x_max, 0x8 y_min,
// 0xC y_max; write them only while no segment is in flight.
// Reset sets x_min and y_min to zero, x_max and y_max to the largest positive
// value, and clears every in-flight word; nothing is emitted afterwards.
// The receiver cannot stall: results must be taken in the cycle done is high.
module line_segment_clip_unit #(
  parameter int COORD_WIDTH = lsc_pkg::COORD_WIDTH,
  parameter int U_FRAC_BITS = lsc_pkg::U_FRAC_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_WIDTH-1:0]      start_x,
  input  logic signed [COORD_WIDTH-1:0]      start_y,
  input  logic signed [COORD_WIDTH-1:0]      end_x,
  input  logic signed [COORD_WIDTH-1:0]      end_y,
  output logic                               done,
  output logic                               visible,
  output logic signed [COORD_WIDTH-1:0]      clip_start_x,
  output logic signed [COORD_WIDTH-1:0]      clip_start_y,
  output logic signed [COORD_WIDTH-1:0]      clip_end_x,
  output logic signed [COORD_WIDTH-1:0]      clip_end_y,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lsc_pkg::ADDR_WIDTH-1:0]     paddr,
  input  logic [lsc_pkg::DATA_WIDTH-1:0]     pwdata,
  output logic [lsc_pkg::DATA_WIDTH-1:0]     prdata,
  output logic                               pready
);

  localparam int W       = COORD_WIDTH;
  localparam int DIV_LAT = U_FRAC_BITS + 3;
  localparam int LAT     = DIV_LAT + 6;
  localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

  logic signed [W-1:0] window_x_min, window_x_max, window_y_min, window_y_max;
  lsc_pkg::reg_index_t reg_sel;
  logic                cfg_write;

  assign busy      = 1'b0;
  assign pready    = 1'b1;
  assign reg_sel   = lsc_pkg::reg_index_t'(paddr[lsc_pkg::ADDR_WIDTH-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_x_min <= '0;
      window_x_max <= MAX_POS;
      window_y_min <= '0;
      window_y_max <= MAX_POS;
    end else if (cfg_write) begin
      unique case (reg_sel)
        lsc_pkg::REG_X_MIN: window_x_min <= pwdata[W-1:0];
        lsc_pkg::REG_X_MAX: window_x_max <= pwdata[W-1:0];
        lsc_pkg::REG_Y_MIN: window_y_min <= pwdata[W-1:0];
        lsc_pkg::REG_Y_MAX: window_y_max <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      lsc_pkg::REG_X_MIN: prdata = lsc_pkg::DATA_WIDTH'($unsigned(window_x_min));
      lsc_pkg::REG_X_MAX: prdata = lsc_pkg::DATA_WIDTH'($unsigned(window_x_max));
      lsc_pkg::REG_Y_MIN: prdata = lsc_pkg::DATA_WIDTH'($unsigned(window_y_min));
      lsc_pkg::REG_Y_MAX: prdata = lsc_pkg::DATA_WIDTH'($unsigned(window_y_max));
      default:            prdata = '0;
    endcase
  end

  logic                in_valid;
  logic signed [W-1:0] in_x1, in_y1, in_x2, in_y2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    in_x1 <= start_x;
    in_y1 <= start_y;
    in_x2 <= end_x;
    in_y2 <= end_y;
  end

  logic                f_valid;
  logic signed [W-1:0] f_x1, f_y1;
  logic signed [W:0]   f_dx, f_dy;
  logic [W-1:0]        f_aq [lsc_pkg::NUM_EDGES];
  logic [W-1:0]        f_ap [lsc_pkg::NUM_EDGES];
  lsc_pkg::edge_set_t  f_flags;
  logic                f_reject;

  lsc_front #(.W(W)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .x1        (in_x1),
    .y1        (in_y1),
    .x2        (in_x2),
    .y2        (in_y2),
    .x_min     (window_x_min),
    .x_max     (window_x_max),
    .y_min     (window_y_min),
    .y_max     (window_y_max),
    .out_valid (f_valid),
    .out_x1    (f_x1),
    .out_y1    (f_y1),
    .out_dx    (f_dx),
    .out_dy    (f_dy),
    .aq        (f_aq),
    .ap        (f_ap),
    .flags     (f_flags),
    .pre_reject(f_reject)
  );

  logic [lsc_pkg::NUM_EDGES-1:0] d_valid;
  logic [U_FRAC_BITS:0]          d_ratio [lsc_pkg::NUM_EDGES];

  for (genvar e = 0; e < lsc_pkg::NUM_EDGES; e++) begin : g_div
    lsc_div #(.AW(W), .UF(U_FRAC_BITS)) u_div (
      .clk      (clk),
      .rst      (rst),
      .in_valid (f_valid),
      .aq       (f_aq[e]),
      .ap       (f_ap[e]),
      .out_valid(d_valid[e]),
      .ratio    (d_ratio[e])
    );
  end

  logic signed [W-1:0] dl_x1 [DIV_LAT];
  logic signed [W-1:0] dl_y1 [DIV_LAT];
  logic signed [W:0]   dl_dx [DIV_LAT];
  logic signed [W:0]   dl_dy [DIV_LAT];
  lsc_pkg::edge_set_t  dl_flags [DIV_LAT];
  logic                dl_reject [DIV_LAT];

  always_ff @(posedge clk) begin
    dl_x1[0]     <= f_x1;
    dl_y1[0]     <= f_y1;
    dl_dx[0]     <= f_dx;
    dl_dy[0]     <= f_dy;
    dl_flags[0]  <= f_flags;
    dl_reject[0] <= f_reject;
    for (int k = 1; k < DIV_LAT; k++) begin
      dl_x1[k]     <= dl_x1[k-1];
      dl_y1[k]     <= dl_y1[k-1];
      dl_dx[k]     <= dl_dx[k-1];
      dl_dy[k]     <= dl_dy[k-1];
      dl_flags[k]  <= dl_flags[k-1];
      dl_reject[k] <= dl_reject[k-1];
    end
  end

  lsc_interp #(.W(W), .UF(U_FRAC_BITS)) u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (&d_valid),
    .ratio     (d_ratio),
    .flags     (dl_flags[DIV_LAT-1]),
    .pre_reject(dl_reject[DIV_LAT-1]),
    .x1        (dl_x1[DIV_LAT-1]),
    .y1        (dl_y1[DIV_LAT-1]),
    .dx        (dl_dx[DIV_LAT-1]),
    .dy        (dl_dy[DIV_LAT-1]),
    .out_valid (done),
    .visible   (visible),
    .out_x1    (clip_start_x),
    .out_y1    (clip_start_y),
    .out_x2    (clip_end_x),
    .out_y2    (clip_end_y)
  );

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result word without an accepted segment");

  a_reject_passes_start: assert property (@(posedge clk) disable iff (rst)
    done && !visible |-> clip_start_x == $past(start_x, LAT))
    else $error("rejected segment start x altered");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (|d_valid) |-> (&d_valid))
    else $error("divider lanes out of step");
`endif

endmodule

// ----- tb/line_segment_clip_unit_tb.sv -----
`timescale 1ns / 100ps

class clip_scoreboard;
  typedef struct packed {
    logic                   vis;
    logic signed [23:0]     sx;
    logic signed [23:0]     sy;
    logic signed [23:0]     ex;
    logic signed [23:0]     ey;
  } clip_word_t;

  clip_word_t pending[$];
  logic signed [23:0] win[4];
  int errors;
  int seen;
  int visible_cnt;

  function new();
    errors = 0;
    seen = 0;
    visible_cnt = 0;
    win[lsc_pkg::REG_X_MIN] = '0;
    win[lsc_pkg::REG_X_MAX] = 24'h7fffff;
    win[lsc_pkg::REG_Y_MIN] = '0;
    win[lsc_pkg::REG_Y_MAX] = 24'h7fffff;
  endfunction

  function longint edge_ratio(longint q, longint p);
    longint aq, ap, r;
    aq = q < 0 ? -q : q;
    ap = p < 0 ? -p : p;
    r = ((aq <<< 17) + ap) / (ap <<< 1);
    if (r > 65537) r = 65537;
    return ((q < 0) != (p < 0)) ? -r : r;
  endfunction

  function longint interp(longint a, longint d, longint u);
    longint mag, r;
    mag = (d < 0 ? -d : d) * u;
    r = (mag + 32768) >>> 16;
    return d < 0 ? a - r : a + r;
  endfunction

  function void note_segment(logic signed [23:0] x1, logic signed [23:0] y1,
                             logic signed [23:0] x2, logic signed [23:0] y2);
    longint dx, dy, u1, u2, r;
    longint p[4], q[4];
    bit ok;
    clip_word_t w;
    dx = longint'(x2) - longint'(x1);
    dy = longint'(y2) - longint'(y1);
    p[0] = -dx; q[0] = longint'(x1) - longint'(win[lsc_pkg::REG_X_MIN]);
    p[1] = dx;  q[1] = longint'(win[lsc_pkg::REG_X_MAX]) - longint'(x1);
    p[2] = -dy; q[2] = longint'(y1) - longint'(win[lsc_pkg::REG_Y_MIN]);
    p[3] = dy;  q[3] = longint'(win[lsc_pkg::REG_Y_MAX]) - longint'(y1);
    ok = 1;
    u1 = 0;
    u2 = 65536;
    for (int i = 0; i < 4; i++) if (p[i] == 0 && q[i] < 0) ok = 0;
    if (ok) begin
      for (int i = 0; i < 4; i++) begin
        if (p[i] != 0) begin
          r = edge_ratio(q[i], p[i]);
          if (p[i] < 0) begin
            if (r > u1) u1 = r;
          end else if (r < u2) begin
            u2 = r;
          end
        end
      end
      if (u1 > u2) ok = 0;
    end
    w.vis = ok;
    w.sx = x1; w.sy = y1; w.ex = x2; w.ey = y2;
    if (ok) begin
      w.sx = 24'(interp(x1, dx, u1));
      w.sy = 24'(interp(y1, dy, u1));
      w.ex = 24'(interp(x1, dx, u2));
      w.ey = 24'(interp(y1, dy, u2));
      visible_cnt++;
    end
    pending.push_back(w);
  endfunction

  function void check_result(clip_word_t got);
    clip_word_t w;
    if (pending.size() == 0) begin
      $error("unexpected result word");
      errors++;
      return;
    end
    w = pending.pop_front();
    seen++;
    if (got.vis !== w.vis) begin
      $error("visible: expected %0d actual %0d", w.vis, got.vis); errors++;
    end
    if (got.sx !== w.sx) begin
      $error("clip_start_x: expected %0d actual %0d", w.sx, got.sx); errors++;
    end
    if (got.sy !== w.sy) begin
      $error("clip_start_y: expected %0d actual %0d", w.sy, got.sy); errors++;
    end
    if (got.ex !== w.ex) begin
      $error("clip_end_x: expected %0d actual %0d", w.ex, got.ex); errors++;
    end
    if (got.ey !== w.ey) begin
      $error("clip_end_y: expected %0d actual %0d", w.ey, got.ey); errors++;
    end
  endfunction
endclass

module line_segment_clip_unit_tb;

  localparam int LATENCY = lsc_pkg::U_FRAC_BITS + 9;
  localparam int WATCHDOG = 5000;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  logic signed [23:0] start_x = '0, start_y = '0, end_x = '0, end_y = '0;
  logic done, visible;
  logic signed [23:0] clip_start_x, clip_start_y, clip_end_x, clip_end_y;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [lsc_pkg::ADDR_WIDTH-1:0] paddr = '0;
  logic [lsc_pkg::DATA_WIDTH-1:0] pwdata = '0;
  logic [lsc_pkg::DATA_WIDTH-1:0] prdata;
  logic pready;

  clip_scoreboard sb = new();
  int idle_cycles = 0;

  always #4 clk = ~clk;

  line_segment_clip_unit u_top (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_segment(start_x, start_y, end_x, end_y);
      if (done) sb.check_result({visible, clip_start_x, clip_start_y, clip_end_x, clip_end_y});
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic write_window(lsc_pkg::reg_index_t idx, logic signed [23:0] val);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= lsc_pkg::ADDR_WIDTH'(idx) << 2;
    pwdata <= lsc_pkg::DATA_WIDTH'(val);
    @(negedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    sb.win[idx] = val;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_segment(logic signed [23:0] x1, logic signed [23:0] y1,
                              logic signed [23:0] x2, logic signed [23:0] y2);
    start <= 1;
    start_x <= x1; start_y <= y1; end_x <= x2; end_y <= y2;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic signed [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(0, 8192)) - 4096);
      default: return 24'($urandom_range(0, 1)) ? 24'h7fffff : 24'h800000;
    endcase
  endfunction

  task automatic random_phase(int n);
    int left, burst, mode;
    logic signed [23:0] px, py;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && left > 0) begin
        mode = ($urandom_range(0, 9) < 7) ? 1 : (($urandom_range(0, 4) == 0) ? 2 : 0);
        if ($urandom_range(0, 15) == 0) begin
          px = rand_coord(mode); py = rand_coord(mode);
          send_segment(px, py, px, py);
        end else begin
          send_segment(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
        end
        burst--; left--;
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    send_segment(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
    send_segment(24'h800000, 24'h000000, 24'h7fffff, 24'h000100);
    send_segment(24'h000100, 24'h000100, 24'h000100, 24'h000100);
    send_segment(-24'sd5, 24'h000100, -24'sd5, 24'h000100);
    drain();

    write_window(lsc_pkg::REG_X_MIN, -24'sd1000);
    write_window(lsc_pkg::REG_X_MAX, 24'sd1000);
    write_window(lsc_pkg::REG_Y_MIN, -24'sd700);
    write_window(lsc_pkg::REG_Y_MAX, 24'sd900);
    send_segment(-24'sd2000, 24'sd0, 24'sd2000, 24'sd0);
    send_segment(24'sd0, -24'sd2000, 24'sd0, 24'sd2000);
    send_segment(-24'sd1500, 24'sd100, -24'sd1500, 24'sd500);
    send_segment(24'sd100, 24'sd950, 24'sd400, 24'sd950);
    send_segment(-24'sd3000, -24'sd3000, 24'sd3000, 24'sd3000);
    send_segment(-24'sd1000, -24'sd700, 24'sd1000, 24'sd900);
    send_segment(-24'sd3000, 24'sd0, 24'sd0, 24'sd3000);
    send_segment(24'sd1000, 24'sd900, 24'sd1000, 24'sd900);
    send_segment(24'sd3, -24'sd5, 24'sd4, -24'sd4);
    send_segment(24'sd500, 24'sd0, -24'sd500, 24'sd1);
    drain();

    write_window(lsc_pkg::REG_X_MIN, 24'sd100);
    write_window(lsc_pkg::REG_X_MAX, -24'sd100);
    send_segment(-24'sd500, 24'sd0, 24'sd500, 24'sd0);
    send_segment(24'sd0, 24'sd0, 24'sd0, 24'sd0);
    drain();

    write_window(lsc_pkg::REG_X_MIN, -24'sd4000);
    write_window(lsc_pkg::REG_X_MAX, 24'sd3000);
    write_window(lsc_pkg::REG_Y_MIN, -24'sd2500);
    write_window(lsc_pkg::REG_Y_MAX, 24'sd3500);
    random_phase(200);
    drain();

    write_window(lsc_pkg::REG_X_MIN, 24'sh800000);
    write_window(lsc_pkg::REG_X_MAX, 24'sh7fffff);
    write_window(lsc_pkg::REG_Y_MIN, 24'sh800000);
    write_window(lsc_pkg::REG_Y_MAX, 24'sh7fffff);
    random_phase(100);
    drain();

    write_window(lsc_pkg::REG_X_MIN, rand_coord(1));
    write_window(lsc_pkg::REG_X_MAX, rand_coord(1));
    write_window(lsc_pkg::REG_Y_MIN, -24'sd300);
    write_window(lsc_pkg::REG_Y_MAX, 24'sd300);
    random_phase(200);
    drain();

    $display("Checked %0d segment words, %0d visible, over six window settings",
             sb.seen, sb.visible_cnt);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
